FILE: rtl/lkvt_pkg.sv
// Package for the linear key-value table: sizes, command and status codes,
// the word types of both channels and the RAM access struct.
// Depends on nothing; every other file of the block but lkvt_ram imports it.
package lkvt_pkg;

    localparam int DEPTH       = 16;
    localparam int KEY_BYTES   = 8;
    localparam int VALUE_WIDTH = 32;

    localparam int KEY_W  = 8 * KEY_BYTES;
    localparam int VAL_W  = VALUE_WIDTH;
    localparam int ENT_W  = KEY_W + VAL_W;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int MAX_W  = 5;
    localparam int CAP_W  = (CNT_W > MAX_W) ? CNT_W : MAX_W;

    localparam int IN_KEY_W   = 64;
    localparam int IN_VAL_W   = 32;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_CNT_W  = 5;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [MAX_W-1:0] MAX_SIZE_RESET = 5'd16;

    // Register index, taken from the word address bits of paddr.
    localparam logic [APB_ADDR_W-3:0] REG_MAX_SIZE = '0;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_SET    = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                cmd;
        logic [IN_KEY_W-1:0] key;
        logic [IN_VAL_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        t_status               status;
        logic                  found;
        logic [OUT_DATA_W-1:0] data;
        logic [OUT_CNT_W-1:0]  count;
    } t_out_word;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [ENT_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

endpackage

FILE: rtl/lkvt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; the table's entries live in one instance of it.
module lkvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/lkvt_ctrl.sv
// Command sequencer: walks the entries through the RAM with one shared key
// comparator, then updates, appends or shifts entries down on a delete.
// Depends on lkvt_pkg.
module lkvt_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  lkvt_pkg::t_in_word            i_word,
    input  logic [lkvt_pkg::MAX_W-1:0]    i_max_size,
    output logic                          o_idle,
    output logic                          o_res_valid,
    output lkvt_pkg::t_out_word           o_res,
    input  logic                          i_res_take,
    output lkvt_pkg::t_ram_req            o_ram,
    input  logic [lkvt_pkg::ENT_W-1:0]    i_rdata
);
    import lkvt_pkg::*;

    // The result waits in a state of its own until the output stage takes it.
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_READ  = 7'b0000010,
        ST_CMP   = 7'b0000100,
        ST_EXEC  = 7'b0001000,
        ST_SH_RD = 7'b0010000,
        ST_SH_WR = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [KEY_W-1:0] r_key, n_key;
    logic [VAL_W-1:0] r_val, n_val;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_hit, n_hit;
    logic [VAL_W-1:0] r_data, n_data;
    logic [CNT_W-1:0] r_count, n_count;
    t_status          r_status, n_status;

    logic [CNT_W-1:0] w_idx_nxt;
    logic             w_key_eq;
    logic             w_full;

    assign w_idx_nxt = CNT_W'(r_idx) + CNT_W'(1);
    assign w_key_eq  = (i_rdata[ENT_W-1 -: KEY_W] == r_key);
    assign w_full    = (CAP_W'(r_count) >= CAP_W'(i_max_size)) ||
                       (CAP_W'(r_count) >= CAP_W'(DEPTH));

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_key    = r_key;
        n_val    = r_val;
        n_idx    = r_idx;
        n_hit    = r_hit;
        n_data   = r_data;
        n_count  = r_count;
        n_status = r_status;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_idx;
        o_ram.wdata = {r_key, r_val};
        o_ram.raddr = r_idx;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_cmd    = i_word.cmd;
                    n_key    = KEY_W'(i_word.key);
                    n_val    = VAL_W'(i_word.value);
                    n_idx    = '0;
                    n_hit    = 1'b0;
                    n_data   = '0;
                    n_status = ST_OK;
                    n_state  = (r_count == '0) ? ST_EXEC : ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (w_key_eq) begin
                    n_hit   = 1'b1;
                    n_data  = i_rdata[VAL_W-1:0];
                    n_state = ST_EXEC;
                end else if (w_idx_nxt >= r_count) begin
                    n_state = ST_EXEC;
                end else begin
                    n_idx   = w_idx_nxt[IDX_W-1:0];
                    n_state = ST_READ;
                end
            end
            ST_EXEC: begin
                n_state = ST_DONE;
                unique case (r_cmd)
                    CMD_LOOKUP: begin
                        if (!r_hit) begin
                            n_status = ST_MISS;
                        end
                    end
                    CMD_SET: begin
                        if (r_hit) begin
                            o_ram.we = 1'b1;
                        end else if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_ram.we    = 1'b1;
                            o_ram.waddr = r_count[IDX_W-1:0];
                            n_count     = r_count + CNT_W'(1);
                        end
                    end
                    CMD_DELETE: begin
                        if (r_hit) begin
                            n_count = r_count - CNT_W'(1);
                            // Entries behind the removed one move down.
                            if (w_idx_nxt < r_count) begin
                                n_state = ST_SH_RD;
                            end
                        end else begin
                            n_status = ST_MISS;
                        end
                    end
                    CMD_NOP: begin
                    end
                    default: begin
                    end
                endcase
            end
            ST_SH_RD: begin
                o_ram.raddr = w_idx_nxt[IDX_W-1:0];
                n_state     = ST_SH_WR;
            end
            ST_SH_WR: begin
                o_ram.we    = 1'b1;
                o_ram.wdata = i_rdata;
                n_idx       = w_idx_nxt[IDX_W-1:0];
                n_state     = (w_idx_nxt < r_count) ? ST_SH_RD : ST_DONE;
            end
            ST_DONE: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_hit    <= n_hit;
        r_data   <= n_data;
        r_status <= n_status;
    end

    assign o_idle       = (r_state == ST_IDLE);
    assign o_res_valid  = (r_state == ST_DONE);
    assign o_res.status = r_status;
    assign o_res.found  = r_hit;
    assign o_res.data   = (r_cmd == CMD_LOOKUP && r_hit) ? OUT_DATA_W'(r_data) : '0;
    assign o_res.count  = OUT_CNT_W'(r_count);

endmodule

FILE: rtl/linear_key_value_table.sv
// Top level of the linear key-value table: APB register, command sequencer,
// entry RAM and the output register. Depends on lkvt_pkg, lkvt_ctrl, lkvt_ram.
//
//   port group   direction  handshake                 word
//   in           input      i_in_valid / o_in_stall   t_in_word  (cmd, key, value)
//   out          output     o_out_valid / i_out_stall t_out_word (status, found, data, count)
//   apb          input      psel, penable, pready     max_size at byte address 0
//
// A command with n entries held reads and compares m <= n of them in turn
// (ST_READ, ST_CMP), one entry at a time through the one key comparator and
// RAM read port, then executes (ST_EXEC); a delete next moves each entry
// behind the removed one down (ST_SH_RD, ST_SH_WR) before ST_DONE.
// One command is in work at a time; the next is taken once the result has
// moved into the output register, which may wait on i_out_stall meanwhile.
// Reset empties the table and sets max_size to 16; no clearing pass is needed.
module linear_key_value_table (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  lkvt_pkg::t_in_word               i_in_word,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output lkvt_pkg::t_out_word              o_out_word,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lkvt_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lkvt_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lkvt_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import lkvt_pkg::*;

    logic [MAX_W-1:0] r_max_size;
    logic             r_out_valid;
    t_out_word        r_out_word;

    logic             w_idle;
    logic             w_start;
    logic             w_res_valid;
    t_out_word        w_res;
    logic             w_take;
    logic             w_cfg_wr;
    logic             w_sel_max;
    t_ram_req         w_ram;
    logic [ENT_W-1:0] w_rdata;

    assign pready    = 1'b1;
    assign w_sel_max = (paddr[APB_ADDR_W-1:2] == REG_MAX_SIZE);
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign prdata    = w_sel_max ? APB_DATA_W'(r_max_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size <= MAX_SIZE_RESET;
        end else if (w_cfg_wr && w_sel_max) begin
            r_max_size <= pwdata[MAX_W-1:0];
        end
    end

    assign o_in_stall = !w_idle;
    assign w_start    = i_in_valid && w_idle;

    lkvt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_word      (i_in_word),
        .i_max_size  (r_max_size),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_take),
        .o_ram       (w_ram),
        .i_rdata     (w_rdata)
    );

    lkvt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata)
    );

    // The output register takes a new word when it is empty or being drained.
    assign w_take = w_res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_take) begin
            r_out_word <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

FILE: rtl/lkvt_chk.sv
// Port-level checker for the linear key-value table, bound to the top level.
// Depends on lkvt_pkg and linear_key_value_table.
module lkvt_chk (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  lkvt_pkg::t_out_word o_out_word,
    input  logic                o_out_valid,
    input  logic                i_out_stall
);
    import lkvt_pkg::*;

    // A command keeps the block busy for at least the cycle after it.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken on two cycles in a row");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled output word changed");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_word.count) <= DEPTH))
        else $error("entry count above table depth");

    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == ST_FULL) |->
        (!o_out_word.found && o_out_word.data == '0))
        else $error("full status with a hit or data");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.found) |-> (o_out_word.status == ST_OK))
        else $error("hit reported with an error status");

endmodule

bind linear_key_value_table lkvt_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_word  (o_out_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall)
);
